// ----- rtl/core/mjji_pkg.sv -----
`timescale 1ns / 1ps

package mjji_pkg;

	localparam int JOINTS    = 7;
	localparam int POS_W     = 32;
	localparam int FRAC      = 16;
	localparam int TIME_W    = 32;
	localparam int REG_W     = 24;
	localparam int KIND_W    = 2;
	localparam int CFG_IDX_W = 2;

	// blend arithmetic widths
	localparam int T_W       = FRAC + 1;
	localparam int P_W       = FRAC + 4;
	localparam int MA_W      = POS_W + 2;
	localparam int MB_W      = P_W + 1;
	localparam int PROD_W    = MA_W + MB_W;
	localparam int JIDX_W    = $clog2(JOINTS);
	localparam int DIV_CNT_W = $clog2(FRAC);

	localparam logic [REG_W-1:0] DURATION_RST = REG_W'(1000000);

	localparam logic [KIND_W-1:0] KIND_START = 2'd0;
	localparam logic [KIND_W-1:0] KIND_GOAL  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MOVE_DURATION = 2'd1;

	typedef logic signed [POS_W-1:0] pos_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_T2,
		ST_T3,
		ST_S,
		ST_SAT,
		ST_MUL,
		ST_ACC,
		ST_FINISH
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CHECK,
		OP_DIV,
		OP_T2,
		OP_T3,
		OP_S,
		OP_SAT,
		OP_MUL,
		OP_ACC,
		OP_LOAD_OUT
	} op_t;

	typedef struct packed {
		logic              take;
		op_t               op;
		logic [JIDX_W-1:0] joint;
	} cmd_t;

	typedef struct packed {
		logic upd;
		logic out_busy;
	} status_t;

endpackage

// ----- rtl/core/mjji_ifs.sv -----
`timescale 1ns / 1ps

interface mjji_in_if;
	logic                              valid;
	logic                              ready;
	logic [mjji_pkg::KIND_W-1:0]       kind;
	logic [mjji_pkg::TIME_W-1:0]       time_us;
	logic signed [mjji_pkg::POS_W-1:0] pos_0;
	logic signed [mjji_pkg::POS_W-1:0] pos_1;
	logic signed [mjji_pkg::POS_W-1:0] pos_2;
	logic signed [mjji_pkg::POS_W-1:0] pos_3;
	logic signed [mjji_pkg::POS_W-1:0] pos_4;
	logic signed [mjji_pkg::POS_W-1:0] pos_5;
	logic signed [mjji_pkg::POS_W-1:0] pos_6;

	modport source (output valid, kind, time_us, pos_0, pos_1, pos_2, pos_3, pos_4, pos_5,
		pos_6, input ready);
	modport sink (input valid, kind, time_us, pos_0, pos_1, pos_2, pos_3, pos_4, pos_5,
		pos_6, output ready);
endinterface

interface mjji_out_if;
	logic                              valid;
	logic                              ready;
	logic                              updated;
	logic signed [mjji_pkg::POS_W-1:0] out_0;
	logic signed [mjji_pkg::POS_W-1:0] out_1;
	logic signed [mjji_pkg::POS_W-1:0] out_2;
	logic signed [mjji_pkg::POS_W-1:0] out_3;
	logic signed [mjji_pkg::POS_W-1:0] out_4;
	logic signed [mjji_pkg::POS_W-1:0] out_5;
	logic signed [mjji_pkg::POS_W-1:0] out_6;

	modport source (output valid, updated, out_0, out_1, out_2, out_3, out_4, out_5, out_6,
		input ready);
	modport sink (input valid, updated, out_0, out_1, out_2, out_3, out_4, out_5, out_6,
		output ready);
endinterface

// ----- rtl/core/min_jerk_joint_interpolator.sv -----
`timescale 1ns / 1ps

// channel   dir   handshake       payload
// in_ch     in    valid/ready     kind, time_us, pos_0..pos_6
// out_ch    out   valid/ready     updated, out_0..out_6
// cfg       in    cfg_we          cfg_idx, cfg_wdata
//
// start pose, goal and unknown kinds are taken in idle and give no result
// a tick that repeats the held pose goes from check to finish; an updating tick runs
// the restoring divider for t, then the shared multiplier runs
// three blend products and a product and an accumulate per joint for the seven joints
// result sits in an output register, so the next item is taken while it waits
// asynchronous active-low reset resets control, trajectory, config and out_valid state only

module min_jerk_joint_interpolator (
	input  logic                            clk,
	input  logic                            arst_n,
	mjji_in_if.sink                         in_ch,
	mjji_out_if.source                      out_ch,
	input  logic                            cfg_we,
	input  logic [mjji_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [mjji_pkg::REG_W-1:0]      cfg_wdata
);

	mjji_pkg::cmd_t    cmd;
	mjji_pkg::status_t st;
	mjji_pkg::pos_t    in_pos   [mjji_pkg::JOINTS];
	mjji_pkg::pos_t    out_pose [mjji_pkg::JOINTS];

	assign in_pos[0] = in_ch.pos_0;
	assign in_pos[1] = in_ch.pos_1;
	assign in_pos[2] = in_ch.pos_2;
	assign in_pos[3] = in_ch.pos_3;
	assign in_pos[4] = in_ch.pos_4;
	assign in_pos[5] = in_ch.pos_5;
	assign in_pos[6] = in_ch.pos_6;

	assign out_ch.out_0 = out_pose[0];
	assign out_ch.out_1 = out_pose[1];
	assign out_ch.out_2 = out_pose[2];
	assign out_ch.out_3 = out_pose[3];
	assign out_ch.out_4 = out_pose[4];
	assign out_ch.out_5 = out_pose[5];
	assign out_ch.out_6 = out_pose[6];

	mjji_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_kind  (in_ch.kind),
		.in_ready (in_ch.ready),
		.st       (st),
		.cmd      (cmd)
	);

	mjji_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata),
		.in_kind     (in_ch.kind),
		.in_time     (in_ch.time_us),
		.in_pos      (in_pos),
		.out_ready   (out_ch.ready),
		.out_valid   (out_ch.valid),
		.out_updated (out_ch.updated),
		.out_pose    (out_pose)
	);

	// a pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == mjji_pkg::OP_LOAD_OUT |-> !(out_ch.valid && !out_ch.ready))
		else $error("result register loaded while a transaction is pending");

	// a tick transaction blocks the input until its result is built
	a_tick_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready && in_ch.kind == mjji_pkg::KIND_TICK |=> !in_ch.ready)
		else $error("input taken while a tick is in flight");

	// each joint accumulate follows the product of the same joint
	a_mul_acc: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == mjji_pkg::OP_ACC |->
			$past(cmd.op) == mjji_pkg::OP_MUL && $past(cmd.joint) == cmd.joint)
		else $error("joint accumulate out of step with multiplier");

endmodule

// ----- rtl/core/mjji_ctrl.sv -----
`timescale 1ns / 1ps

module mjji_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [mjji_pkg::KIND_W-1:0]   in_kind,
	output logic                          in_ready,
	input  mjji_pkg::status_t             st,
	output mjji_pkg::cmd_t                cmd
);

	mjji_pkg::state_t state_q, state_nxt;
	logic [mjji_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [mjji_pkg::JIDX_W-1:0]    joint_q;
	logic div_last, joint_last;

	assign div_last   = (cnt_q == mjji_pkg::DIV_CNT_W'(mjji_pkg::FRAC - 1));
	assign joint_last = (joint_q == mjji_pkg::JIDX_W'(mjji_pkg::JOINTS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mjji_pkg::ST_IDLE;
			cnt_q   <= '0;
			joint_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == mjji_pkg::ST_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			if (state_q == mjji_pkg::ST_ACC) begin
				joint_q <= joint_last ? '0 : joint_q + 1'b1;
			end else if (state_q != mjji_pkg::ST_MUL) begin
				joint_q <= '0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			mjji_pkg::ST_IDLE: begin
				if (in_valid && in_kind == mjji_pkg::KIND_TICK) begin
					state_nxt = mjji_pkg::ST_CHECK;
				end
			end
			mjji_pkg::ST_CHECK:  state_nxt = st.upd ? mjji_pkg::ST_DIV : mjji_pkg::ST_FINISH;
			mjji_pkg::ST_DIV: begin
				if (div_last) begin
					state_nxt = mjji_pkg::ST_T2;
				end
			end
			mjji_pkg::ST_T2:     state_nxt = mjji_pkg::ST_T3;
			mjji_pkg::ST_T3:     state_nxt = mjji_pkg::ST_S;
			mjji_pkg::ST_S:      state_nxt = mjji_pkg::ST_SAT;
			mjji_pkg::ST_SAT:    state_nxt = mjji_pkg::ST_MUL;
			mjji_pkg::ST_MUL:    state_nxt = mjji_pkg::ST_ACC;
			mjji_pkg::ST_ACC:    state_nxt = joint_last ? mjji_pkg::ST_FINISH : mjji_pkg::ST_MUL;
			mjji_pkg::ST_FINISH: begin
				if (!st.out_busy) begin
					state_nxt = mjji_pkg::ST_IDLE;
				end
			end
			default:             state_nxt = mjji_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		cmd.take  = 1'b0;
		cmd.op    = mjji_pkg::OP_NONE;
		cmd.joint = joint_q;
		unique case (state_q)
			mjji_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
			end
			mjji_pkg::ST_CHECK:  cmd.op = mjji_pkg::OP_CHECK;
			mjji_pkg::ST_DIV:    cmd.op = mjji_pkg::OP_DIV;
			mjji_pkg::ST_T2:     cmd.op = mjji_pkg::OP_T2;
			mjji_pkg::ST_T3:     cmd.op = mjji_pkg::OP_T3;
			mjji_pkg::ST_S:      cmd.op = mjji_pkg::OP_S;
			mjji_pkg::ST_SAT:    cmd.op = mjji_pkg::OP_SAT;
			mjji_pkg::ST_MUL:    cmd.op = mjji_pkg::OP_MUL;
			mjji_pkg::ST_ACC:    cmd.op = mjji_pkg::OP_ACC;
			mjji_pkg::ST_FINISH: begin
				if (!st.out_busy) begin
					cmd.op = mjji_pkg::OP_LOAD_OUT;
				end
			end
			default:             cmd.op = mjji_pkg::OP_NONE;
		endcase
	end

endmodule

// ----- rtl/core/mjji_dpath.sv -----
`timescale 1ns / 1ps

module mjji_dpath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  mjji_pkg::cmd_t                   cmd,
	output mjji_pkg::status_t                st,
	input  logic                             cfg_we,
	input  logic [mjji_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [mjji_pkg::REG_W-1:0]       cfg_wdata,
	input  logic [mjji_pkg::KIND_W-1:0]      in_kind,
	input  logic [mjji_pkg::TIME_W-1:0]      in_time,
	input  mjji_pkg::pos_t                   in_pos [mjji_pkg::JOINTS],
	input  logic                             out_ready,
	output logic                             out_valid,
	output logic                             out_updated,
	output mjji_pkg::pos_t                   out_pose [mjji_pkg::JOINTS]
);

	localparam int T_W    = mjji_pkg::T_W;
	localparam int P_W    = mjji_pkg::P_W;
	localparam int FRAC   = mjji_pkg::FRAC;
	localparam int REG_W  = mjji_pkg::REG_W;
	localparam int TIME_W = mjji_pkg::TIME_W;
	localparam int POS_W  = mjji_pkg::POS_W;
	localparam int SUM_W  = P_W + 3;
	localparam logic [T_W-1:0]   T_ONE   = T_W'(1) << FRAC;
	localparam logic [SUM_W-1:0] TEN_ONE = SUM_W'(10) << FRAC;

	// configuration
	logic [REG_W-1:0] period_q, duration_q;

	// trajectory state
	mjji_pkg::pos_t start_q [mjji_pkg::JOINTS];
	mjji_pkg::pos_t goal_q  [mjji_pkg::JOINTS];
	mjji_pkg::pos_t held_q  [mjji_pkg::JOINTS];
	logic [TIME_W-1:0] motion_q, last_upd_q, elapsed_q;
	logic started_q, awaiting_q, upd_q;

	// blend unit
	logic [REG_W-1:0] rem_q;
	logic [T_W-1:0]   t_q, s_q;
	logic             tsat_q;
	logic [P_W-1:0]   p_q;
	logic signed [mjji_pkg::PROD_W-1:0] prod_q;
	logic signed [mjji_pkg::MA_W-1:0]   mul_a;
	logic signed [mjji_pkg::MB_W-1:0]   mul_b;

	logic                out_valid_q, out_upd_q;
	mjji_pkg::pos_t      out_pose_q [mjji_pkg::JOINTS];

	logic [REG_W:0]      rem_dbl;
	logic                rem_ge;
	logic [T_W-1:0]      prod_hi;
	logic [SUM_W-1:0]    t2_x, t_x, p_sum;
	logic [T_W+P_W-FRAC-1:0] s_raw;
	logic [TIME_W-1:0]   since_upd;

	assign since_upd = in_time - last_upd_q;
	assign rem_dbl   = {rem_q, 1'b0};
	assign rem_ge    = (rem_dbl >= {1'b0, duration_q});
	assign prod_hi   = prod_q[2*FRAC:FRAC];
	assign t2_x      = SUM_W'(prod_hi);
	assign t_x       = SUM_W'(t_q);
	// p = 10 - 15t + 6t^2, stays positive over [0, 1]
	assign p_sum     = TEN_ONE + (t2_x << 2) + (t2_x << 1) - ((t_x << 4) - t_x);
	assign s_raw     = prod_q[T_W+P_W-1:FRAC];

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			mjji_pkg::OP_T2: begin
				mul_a = mjji_pkg::MA_W'(t_q);
				mul_b = mjji_pkg::MB_W'(t_q);
			end
			mjji_pkg::OP_T3: begin
				mul_a = mjji_pkg::MA_W'(prod_hi);
				mul_b = mjji_pkg::MB_W'(t_q);
			end
			mjji_pkg::OP_S: begin
				mul_a = mjji_pkg::MA_W'(prod_hi);
				mul_b = mjji_pkg::MB_W'(p_q);
			end
			mjji_pkg::OP_MUL: begin
				mul_a = mjji_pkg::MA_W'(goal_q[cmd.joint]) - mjji_pkg::MA_W'(start_q[cmd.joint]);
				mul_b = mjji_pkg::MB_W'(s_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q   <= '0;
			duration_q <= mjji_pkg::DURATION_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				mjji_pkg::REG_SAMPLE_PERIOD: period_q   <= cfg_wdata;
				mjji_pkg::REG_MOVE_DURATION: duration_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < mjji_pkg::JOINTS; j++) begin
				start_q[j] <= '0;
				goal_q[j]  <= '0;
				held_q[j]  <= '0;
			end
			motion_q   <= '0;
			last_upd_q <= '0;
			elapsed_q  <= '0;
			started_q  <= 1'b0;
			awaiting_q <= 1'b1;
			upd_q      <= 1'b0;
		end else if (cmd.take) begin
			case (in_kind)
				mjji_pkg::KIND_START: begin
					if (awaiting_q) begin
						for (int j = 0; j < mjji_pkg::JOINTS; j++) begin
							start_q[j] <= in_pos[j];
						end
					end
				end
				mjji_pkg::KIND_GOAL: begin
					last_upd_q <= in_time;
					motion_q   <= in_time;
					started_q  <= 1'b0;
					awaiting_q <= 1'b0;
					for (int j = 0; j < mjji_pkg::JOINTS; j++) begin
						if (!awaiting_q) begin
							start_q[j] <= goal_q[j];
						end
						goal_q[j] <= in_pos[j];
					end
				end
				mjji_pkg::KIND_TICK: begin
					// first tick of a move latches its start time
					if (!started_q) begin
						motion_q  <= in_time;
						started_q <= 1'b1;
						elapsed_q <= '0;
						for (int j = 0; j < mjji_pkg::JOINTS; j++) begin
							held_q[j] <= start_q[j];
						end
					end else begin
						elapsed_q <= in_time - motion_q;
					end
					upd_q <= (since_upd >= TIME_W'(period_q));
					if (since_upd >= TIME_W'(period_q)) begin
						last_upd_q <= in_time;
					end
				end
				default: ;
			endcase
		end else if (cmd.op == mjji_pkg::OP_ACC) begin
			held_q[cmd.joint] <= start_q[cmd.joint] + prod_q[POS_W+FRAC-1:FRAC];
		end
	end

	// restoring divider (one quotient bit per cycle, t is one if elapsed >= duration) and blend products
	always_ff @(posedge clk) begin
		case (cmd.op)
			mjji_pkg::OP_CHECK: begin
				if (elapsed_q >= TIME_W'(duration_q)) begin
					tsat_q <= 1'b1;
					t_q    <= T_ONE;
				end else begin
					tsat_q <= 1'b0;
					t_q    <= '0;
				end
				rem_q <= elapsed_q[REG_W-1:0];
			end
			mjji_pkg::OP_DIV: begin
				if (!tsat_q) begin
					t_q   <= {t_q[T_W-2:0], rem_ge};
					rem_q <= rem_ge ? rem_dbl[REG_W-1:0] - duration_q : rem_dbl[REG_W-1:0];
				end
			end
			mjji_pkg::OP_T2: prod_q <= mul_a * mul_b;
			mjji_pkg::OP_T3: begin
				prod_q <= mul_a * mul_b;
				p_q    <= p_sum[P_W-1:0];
			end
			mjji_pkg::OP_S:   prod_q <= mul_a * mul_b;
			mjji_pkg::OP_SAT: s_q    <= (s_raw > (T_W+P_W-FRAC)'(T_ONE)) ? T_ONE : s_raw[T_W-1:0];
			mjji_pkg::OP_MUL: prod_q <= mul_a * mul_b;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == mjji_pkg::OP_LOAD_OUT) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == mjji_pkg::OP_LOAD_OUT) begin
			out_upd_q <= upd_q;
			for (int j = 0; j < mjji_pkg::JOINTS; j++) begin
				out_pose_q[j] <= held_q[j];
			end
		end
	end

	assign st.upd      = upd_q;
	assign st.out_busy = out_valid_q && !out_ready;
	assign out_valid   = out_valid_q;
	assign out_updated = out_upd_q;
	assign out_pose    = out_pose_q;

endmodule
